// File: src/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Types, constants and helpers shared by the glyph text rasterizer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  // Screen, glyph and font store limits.
  localparam int SCREEN_W     = 800;
  localparam int SCREEN_H     = 480;
  localparam int MAX_GLYPH_W  = 8;
  localparam int MAX_GLYPH_H  = 8;
  localparam int BITMAP_BYTES = 8192;
  localparam int BITMAP_AW    = $clog2(BITMAP_BYTES);

  // Printable code range and glyph table size.
  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam logic [7:0] LAST_CODE   = 8'd126;
  localparam int         GLYPH_COUNT = 95;
  localparam int         GLYPH_AW    = $clog2(GLYPH_COUNT);

  // Width of the signed screen position arithmetic.
  localparam int POS_W = 26;

  // Largest value of the running y minimum at the start of a string.
  localparam logic signed [15:0] YMIN_START = 16'sd32767;

  // Input item kinds.
  typedef enum logic [2:0] {
    KIND_GLYPH  = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_SMEAS  = 3'd2,
    KIND_SDRAW  = 3'd3,
    KIND_CHAR   = 3'd4,
    KIND_END    = 3'd5
  } kind_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_DEPTH = 1'b0,
    REG_COLOR = 1'b1
  } reg_index_t;

  // Result types.
  localparam logic OUT_PIXEL   = 1'b0;
  localparam logic OUT_METRICS = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GLYPH,
    S_SETUP,
    S_READ,
    S_EMIT,
    S_FLUSH,
    S_FINISH,
    S_METRIC
  } state_t;

  // One glyph table entry.
  typedef struct packed {
    logic [3:0]           w;
    logic [3:0]           h;
    logic signed [7:0]    xb;
    logic signed [7:0]    yb;
    logic [7:0]           adv;
    logic [BITMAP_AW-1:0] addr;
  } glyph_t;

  // Scale an unpacked pixel value up to a full coverage byte.
  function automatic logic [7:0] scale_cov(input logic [7:0] raw, input logic [1:0] depth);
    logic [7:0] v;
    begin
      unique case (depth)
        2'd0:    v = raw[0] ? 8'hff : 8'h00;
        2'd1:    v = 8'({6'b0, raw[1:0]} * 8'd85);
        2'd2:    v = 8'({4'b0, raw[3:0]} * 8'd17);
        default: v = raw;
      endcase
      return v;
    end
  endfunction

endpackage

// File: src/gtr_in_if.sv
// ----------------------------------------------------------------------------
// gtr_in_if
// Input channel of the glyph text rasterizer: handshake and item fields.
// ----------------------------------------------------------------------------
interface gtr_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         code;
  logic [3:0]         glyph_width;
  logic [3:0]         glyph_height;
  logic signed [7:0]  x_bearing;
  logic signed [7:0]  y_bearing;
  logic [7:0]         advance;
  logic [12:0]        bitmap_address;
  logic [7:0]         data_byte;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic               absolute;

  modport source (output valid, kind, code, glyph_width, glyph_height, x_bearing,
                  y_bearing, advance, bitmap_address, data_byte, origin_x, origin_y,
                  absolute, input ready);
  modport sink (input valid, kind, code, glyph_width, glyph_height, x_bearing,
                y_bearing, advance, bitmap_address, data_byte, origin_x, origin_y,
                absolute, output ready);
endinterface

// File: src/gtr_out_if.sv
// ----------------------------------------------------------------------------
// gtr_out_if
// Output channel of the glyph text rasterizer: handshake and result fields.
// ----------------------------------------------------------------------------
interface gtr_out_if;
  logic               valid;
  logic               ready;
  logic               out_type;
  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic [31:0]        blend_word;
  logic signed [23:0] cursor_pos;
  logic signed [23:0] text_width;
  logic signed [15:0] y_low;
  logic signed [15:0] y_high;
  logic               last;

  modport source (output valid, out_type, pixel_x, pixel_y, blend_word, cursor_pos,
                  text_width, y_low, y_high, last, input ready);
  modport sink (input valid, out_type, pixel_x, pixel_y, blend_word, cursor_pos,
                text_width, y_low, y_high, last, output ready);
endinterface

// File: src/gtr_bitmap_ram.sv
// ----------------------------------------------------------------------------
// gtr_bitmap_ram
// Font bitmap store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gtr_bitmap_ram
  import gtr_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [BITMAP_AW-1:0] waddr,
  input  logic [7:0]           wdata,
  input  logic                 re,
  input  logic [BITMAP_AW-1:0] raddr,
  output logic [7:0]           rdata
);

  logic [7:0] mem [BITMAP_BYTES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/glyph_text_rasterizer.sv
// A load, start or non-printable character item is taken in S_IDLE alone; an end item
// passes S_METRIC and gives its metrics once the output register is free.
// A printable character passes S_GLYPH, S_SETUP and S_FINISH in measure mode.
// Draw mode adds S_READ and S_EMIT for each glyph pixel and S_FLUSH; output stalls hold it.
// The pixel loop is set by the bitmap memory read, one pixel per read and compare.
// Reset clears cursor, extent, origin and mode, presets config; font stores are kept as is.
// ----------------------------------------------------------------------------
// glyph_text_rasterizer
// Font loading, string measurement and clipped glyph drawing into blend writes.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer
  import gtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gtr_in_if.sink      in_ch,
  gtr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  state_t state, state_next;

  // Configuration registers.
  logic [1:0]  depth_code;
  logic [23:0] text_color;

  // String state.
  logic [23:0]        cursor_reg;
  logic [23:0]        width_reg;
  logic signed [15:0] ymin_reg;
  logic signed [15:0] ymax_reg;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic               flag_draw;
  logic               flag_abs;
  logic               flag_first;
  logic               first_hit;

  // Glyph table and current glyph.
  glyph_t glyph_table [GLYPH_COUNT];
  glyph_t g;

  // Pixel loop.
  logic signed [POS_W-1:0] bx, tx, ty;
  logic [2:0]  sx, sy;
  logic [5:0]  idx;
  logic [2:0]  bit_off;
  logic [7:0]  ram_rdata;
  logic [8:0]  bitpos;

  // Pending pixel, held back until it is known whether it is the last one.
  logic       pend_valid;
  logic [9:0] pend_x, pend_y;
  logic [7:0] pend_cov;

  // Control.
  logic in_acc, printable, slot_free, vis, push, row_end, col_end;
  logic emit_go, ram_re;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign printable   = (in_ch.code >= FIRST_CODE) && (in_ch.code <= LAST_CODE);
  assign slot_free   = !out_ch.valid || out_ch.ready;
  assign bitpos      = 9'({3'b0, idx} << depth_code);

  // Visibility and loop position of the current pixel.
  always_comb begin
    vis = !tx[POS_W-1] && (tx < POS_W'(SCREEN_W)) &&
          !ty[POS_W-1] && (ty < POS_W'(SCREEN_H));
    col_end = ({1'b0, sx} == g.w - 4'd1);
    row_end = ({1'b0, sy} == g.h - 4'd1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_CHAR && printable) state_next = S_GLYPH;
          else if (in_ch.kind == KIND_END) state_next = S_METRIC;
        end
      end
      S_GLYPH: state_next = S_SETUP;
      S_SETUP: begin
        if (flag_draw && g.w != 4'd0 && g.h != 4'd0) state_next = S_READ;
        else state_next = S_FINISH;
      end
      S_READ: state_next = S_EMIT;
      S_EMIT: begin
        if (emit_go) state_next = (col_end && row_end) ? S_FLUSH : S_READ;
      end
      S_FLUSH: begin
        if (!pend_valid || slot_free) state_next = S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      S_METRIC: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    emit_go = (state == S_EMIT) && (!vis || !pend_valid || slot_free);
    push    = (emit_go && vis && pend_valid) ||
              (state == S_FLUSH && pend_valid && slot_free);
    ram_re  = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code <= 2'd0;
      text_color <= 24'hffffff;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEPTH: depth_code <= cfg_data[1:0];
        REG_COLOR: text_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Glyph table: write on metric loads, registered read for characters.
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == KIND_GLYPH && printable) begin
      glyph_table[GLYPH_AW'(in_ch.code - FIRST_CODE)] <= '{
        w:    (in_ch.glyph_width  > 4'(MAX_GLYPH_W)) ? 4'(MAX_GLYPH_W) : in_ch.glyph_width,
        h:    (in_ch.glyph_height > 4'(MAX_GLYPH_H)) ? 4'(MAX_GLYPH_H) : in_ch.glyph_height,
        xb:   in_ch.x_bearing,
        yb:   in_ch.y_bearing,
        adv:  in_ch.advance,
        addr: in_ch.bitmap_address
      };
    end
    if (in_acc && in_ch.kind == KIND_CHAR && printable) begin
      g <= glyph_table[GLYPH_AW'(in_ch.code - FIRST_CODE)];
    end
  end

  gtr_bitmap_ram u_ram (
    .clk   (clk),
    .we    (in_acc && in_ch.kind == KIND_BYTE),
    .waddr (in_ch.bitmap_address),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (g.addr + BITMAP_AW'(bitpos[8:3])),
    .rdata (ram_rdata)
  );

  // String state and pixel loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_reg <= '0;
      width_reg  <= '0;
      ymin_reg   <= '0;
      ymax_reg   <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
      flag_draw  <= 1'b0;
      flag_abs   <= 1'b0;
      flag_first <= 1'b0;
      first_hit  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (in_acc && (in_ch.kind == KIND_SMEAS || in_ch.kind == KIND_SDRAW)) begin
        cursor_reg <= '0;
        width_reg  <= '0;
        ymin_reg   <= '0;
        ymax_reg   <= '0;
        origin_x   <= in_ch.origin_x;
        origin_y   <= in_ch.origin_y;
        flag_draw  <= (in_ch.kind == KIND_SDRAW);
        flag_abs   <= in_ch.absolute;
        flag_first <= 1'b1;
      end
      // A character item closes the first-character window.
      if (in_acc && in_ch.kind == KIND_CHAR) begin
        flag_first <= 1'b0;
        first_hit  <= flag_first;
        if (flag_first) ymin_reg <= YMIN_START;
      end
      // Trim the first glyph's bearing in absolute mode.
      if (state == S_GLYPH && first_hit && flag_abs) begin
        cursor_reg <= cursor_reg - {{16{g.xb[7]}}, g.xb};
      end
      if (state == S_EMIT && emit_go && vis) begin
        pend_valid <= 1'b1;
      end else if (state == S_FLUSH && push) begin
        pend_valid <= 1'b0;
      end
      // Advance cursor and extent once the glyph is done; extent compares are signed.
      if (state == S_FINISH) begin
        width_reg  <= cursor_reg + {20'b0, g.w} + {{16{g.xb[7]}}, g.xb};
        cursor_reg <= cursor_reg + {16'b0, g.adv};
        if (g.w != 4'd0) begin
          if ($signed({{8{g.yb[7]}}, g.yb}) < ymin_reg) ymin_reg <= {{8{g.yb[7]}}, g.yb};
          if ($signed({{8{g.yb[7]}}, g.yb}) + $signed({12'b0, g.h}) > ymax_reg) begin
            ymax_reg <= {{8{g.yb[7]}}, g.yb} + $signed({12'b0, g.h});
          end
        end
      end
    end
  end

  // Pixel loop datapath.
  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      bx  <= POS_W'(origin_x) + POS_W'($signed(cursor_reg)) + POS_W'(g.xb);
      tx  <= POS_W'(origin_x) + POS_W'($signed(cursor_reg)) + POS_W'(g.xb);
      ty  <= POS_W'(origin_y) + POS_W'(g.yb);
      sx  <= '0;
      sy  <= '0;
      idx <= '0;
    end
    if (state == S_READ) begin
      bit_off <= bitpos[2:0];
    end
    if (emit_go) begin
      if (vis) begin
        pend_x   <= tx[9:0];
        pend_y   <= ty[9:0];
        pend_cov <= scale_cov(ram_rdata >> bit_off, depth_code);
      end
      idx <= idx + 6'd1;
      if (col_end) begin
        sx <= '0;
        tx <= bx;
        sy <= sy + 3'd1;
        ty <= ty + POS_W'(1);
      end else begin
        sx <= sx + 3'd1;
        tx <= tx + POS_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (push || (state == S_METRIC && slot_free)) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_ch.out_type   <= OUT_PIXEL;
      out_ch.pixel_x    <= pend_x;
      out_ch.pixel_y    <= pend_y;
      out_ch.blend_word <= {text_color, pend_cov};
      out_ch.cursor_pos <= '0;
      out_ch.text_width <= '0;
      out_ch.y_low      <= '0;
      out_ch.y_high     <= '0;
      out_ch.last       <= (state == S_FLUSH);
    end else if (state == S_METRIC && slot_free) begin
      out_ch.out_type   <= OUT_METRICS;
      out_ch.pixel_x    <= '0;
      out_ch.pixel_y    <= '0;
      out_ch.blend_word <= '0;
      out_ch.cursor_pos <= cursor_reg;
      out_ch.text_width <= width_reg;
      out_ch.y_low      <= ymin_reg;
      out_ch.y_high     <= ymax_reg;
      out_ch.last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_push_slot: assert property (@(posedge clk) disable iff (rst) push |-> slot_free)
    else $error("result pushed into a full output register");
  a_metric_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_type == OUT_METRICS) |-> out_ch.last)
    else $error("metrics result without last");
  a_pix_on_screen: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_type == OUT_PIXEL) |->
    (out_ch.pixel_x < 10'(SCREEN_W) && out_ch.pixel_y < 10'(SCREEN_H)))
    else $error("blend write outside the screen");
  a_pend_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending pixel left behind after a character");
`endif

endmodule
